[hdl/pct_pkg.sv]
package pct_pkg;

  localparam int COORD_BITS = 12;
  localparam int VALUE_BITS = 32;
  localparam int SCALE_W    = 6;
  localparam int CAPS_W     = 3;
  localparam int BTN_W      = 3;
  localparam int BTN_ID_W   = 2;
  localparam int MODE_W     = 3;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = (VALUE_BITS > COORD_BITS) ? VALUE_BITS : COORD_BITS;

  // Magnitude of the difference of two signed values, the scaled numerator and
  // the partial remainder of the serial divider.
  localparam int MAG_W      = VALUE_BITS + 1;
  localparam int NUM_W      = MAG_W + COORD_BITS;
  localparam int REM_W      = MAG_W + 1;
  localparam int MAP_CNT_W  = $clog2(NUM_W);

  // Relative path: position plus count times scale, with a sign bit on top.
  localparam int REL_RAW_W  = (VALUE_BITS + SCALE_W > COORD_BITS + 1) ?
                              (VALUE_BITS + SCALE_W) : (COORD_BITS + 1);
  localparam int REL_W      = REL_RAW_W + 1;
  localparam int REL_CNT_W  = $clog2(SCALE_W);

  localparam logic [COORD_BITS-1:0] RST_MAX_X = COORD_BITS'(1023);
  localparam logic [COORD_BITS-1:0] RST_MAX_Y = COORD_BITS'(767);
  localparam logic [COORD_BITS-1:0] RST_POS_X = COORD_BITS'((int'(RST_MAX_X) + 1) / 2);
  localparam logic [COORD_BITS-1:0] RST_POS_Y = COORD_BITS'((int'(RST_MAX_Y) + 1) / 2);
  localparam logic [SCALE_W-1:0]    RST_SCALE = SCALE_W'(8);
  localparam logic [CAPS_W-1:0]     RST_CAPS  = CAPS_W'(1);

  localparam int CAP_POINTER = 0;
  localparam int CAP_ABS_X   = 1;
  localparam int CAP_ABS_Y   = 2;

  localparam logic [MODE_W-1:0] MODE_REL_X  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REL_Y  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ABS_X  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABS_Y  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BUTTON = 3'd4;

  localparam logic [BTN_ID_W-1:0] BTN_OTHER = 2'd3;

  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_MAX_X = 3'd0,
    CFG_SCREEN_MAX_Y = 3'd1,
    CFG_REL_SCALE    = 3'd2,
    CFG_AXIS_X_MIN   = 3'd3,
    CFG_AXIS_X_MAX   = 3'd4,
    CFG_AXIS_Y_MIN   = 3'd5,
    CFG_AXIS_Y_MAX   = 3'd6,
    CFG_DEVICE_CAPS  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_REL_FIN,
    S_PREP,
    S_ABS,
    S_EMIT
  } pct_state_e;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_DIV,
    M_DONE
  } map_state_e;

  typedef struct packed {
    logic                  start;
    logic                  neg;
    logic [MAG_W-1:0]      diff_mag;
    logic [MAG_W-1:0]      span_mag;
    logic [COORD_BITS-1:0] max;
  } map_req_t;

  typedef struct packed {
    logic                  done;
    logic [COORD_BITS-1:0] coord;
  } map_rsp_t;

endpackage

[hdl/pct_abs_map.sv]
// Serial absolute-axis mapper: shift-add multiply by the screen maximum, one
// multiplier bit per cycle, then a restoring divide, one quotient bit per cycle.
module pct_abs_map import pct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output map_rsp_t rsp_o
);

  map_state_e            state_q, state_d;
  logic [MAP_CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0]      mcand_q, mcand_d;
  logic [COORD_BITS-1:0] mplier_q, mplier_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [MAG_W-1:0]      dvs_q, dvs_d;
  logic [MAG_W-1:0]      rem_q, rem_d;
  logic [COORD_BITS-1:0] quo_q, quo_d;
  logic                  ovf_q, ovf_d;
  logic                  neg_q, neg_d;
  logic [COORD_BITS-1:0] max_q, max_d;
  logic [COORD_BITS-1:0] coord_q, coord_d;
  logic                  done_q, done_d;

  logic [REM_W-1:0]      rem_next;
  logic [REM_W:0]        sub_w;
  logic                  borrow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    num_q    <= num_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    ovf_q    <= ovf_d;
    neg_q    <= neg_d;
    max_q    <= max_d;
    coord_q  <= coord_d;
  end

  assign rem_next = {rem_q, num_q[NUM_W-1]};
  assign sub_w    = {1'b0, rem_next} - (REM_W + 1)'(dvs_q);
  assign borrow   = sub_w[REM_W];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    num_d    = num_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    ovf_d    = ovf_q;
    neg_d    = neg_q;
    max_d    = max_q;
    coord_d  = coord_q;
    done_d   = 1'b0;

    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          mcand_d  = NUM_W'(req_i.diff_mag);
          mplier_d = req_i.max;
          max_d    = req_i.max;
          neg_d    = req_i.neg;
          dvs_d    = req_i.span_mag;
          num_d    = '0;
          rem_d    = '0;
          quo_d    = '0;
          ovf_d    = 1'b0;
          cnt_d    = MAP_CNT_W'(COORD_BITS - 1);
          state_d  = M_MUL;
        end
      end
      M_MUL: begin
        if (mplier_q[0]) begin
          num_d = num_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        if (cnt_q == '0) begin
          cnt_d   = MAP_CNT_W'(NUM_W - 1);
          state_d = M_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      M_DIV: begin
        num_d = num_q << 1;
        rem_d = borrow ? rem_next[MAG_W-1:0] : sub_w[MAG_W-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], ~borrow};
        // Any quotient bit pushed out of the top means the result saturates.
        ovf_d = ovf_q | quo_q[COORD_BITS-1];
        if (cnt_q == '0) begin
          state_d = M_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      M_DONE: begin
        if (neg_q) begin
          coord_d = '0;
        end else if (ovf_q || (quo_q > max_q)) begin
          coord_d = max_q;
        end else begin
          coord_d = quo_q;
        end
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.coord = coord_q;

endmodule

[hdl/pointer_cursor_tracker_unit.sv]
// Pointer cursor tracker.
// Input channel: one pointer event per word (mode_i, button_id_i, event_value_i),
// taken at a clock edge with in_valid_i high and in_stall_o low. in_stall_o is
// high while an event is being worked on, so events are handled one at a time.
// Output channel: at most one result word per event, held on the output
// register until a clock edge with out_valid_o high and out_stall_i low. While
// the receiver stalls, the block still takes and computes the next event and
// parks its result until the output register frees up.
// With an idle receiver, a button event goes straight to the emit state, a
// relative move first runs the shift-add multiplier, one scale bit per cycle,
// and an absolute move the serial mapper, which multiplies one screen-max bit
// per cycle and then divides one quotient bit per cycle. in_stall_o drops in
// the cycle that the word appears. Ignored events (no pointer, unknown mode,
// other button, uncalibrated axis) give no word.
// Configuration: cfg_ready_o is always high; write only while the block is idle.
// Reset puts every configuration register at its documented reset value, centers the cursor
// and releases all buttons; no word is pending after reset.
module pointer_cursor_tracker_unit import pct_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Event input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [MODE_W-1:0]            mode_i,
  input  logic [BTN_ID_W-1:0]          button_id_i,
  input  logic signed [VALUE_BITS-1:0] event_value_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         result_kind_o,
  output logic [BTN_W-1:0]             button_mask_o,
  output logic [BTN_W-1:0]             changed_button_o,
  output logic [COORD_BITS-1:0]        cursor_x_o,
  output logic [COORD_BITS-1:0]        cursor_y_o,
  output logic signed [DELTA_W-1:0]    delta_x_o,
  output logic signed [DELTA_W-1:0]    delta_y_o,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]             cfg_data_i
);

  // Configuration registers.
  logic [COORD_BITS-1:0] max_x_q, max_y_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [VALUE_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic [CAPS_W-1:0]     caps_q;

  // Cursor state.
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [BTN_W-1:0]      held_q, held_d;

  pct_state_e            state_q, state_d;
  logic                  axis_y_q, axis_y_d;

  // Relative move: shift-add multiplier working on the accumulated position.
  logic [REL_W-1:0]      acc_q, acc_d;
  logic [REL_W-1:0]      mcand_q, mcand_d;
  logic [SCALE_W-1:0]    sh_q, sh_d;
  logic [REL_CNT_W-1:0]  rcnt_q, rcnt_d;

  // Absolute move: signed offset and span, handed to the mapper.
  logic [MAG_W-1:0]      diff_q, diff_d, span_q, span_d;

  // Result waiting for the output register.
  logic                  pend_kind_q, pend_kind_d;
  logic [BTN_W-1:0]      pend_chg_q, pend_chg_d;
  logic [DELTA_W-1:0]    pend_dx_q, pend_dx_d, pend_dy_q, pend_dy_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q, out_kind_d;
  logic [BTN_W-1:0]      out_mask_q, out_mask_d, out_chg_q, out_chg_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [DELTA_W-1:0]    out_dx_q, out_dx_d, out_dy_q, out_dy_d;

  map_req_t              map_req;
  map_rsp_t              map_rsp;

  logic [COORD_BITS-1:0] axis_max;
  logic [COORD_BITS-1:0] axis_old;
  logic                  fin_en;
  logic [COORD_BITS-1:0] fin_coord;
  logic [DELTA_W-1:0]    fin_delta;
  logic [MAG_W-1:0]      value_ext;
  logic [BTN_W-1:0]      btn_bit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= RST_MAX_X;
      max_y_q <= RST_MAX_Y;
      scale_q <= RST_SCALE;
      x_min_q <= '0;
      x_max_q <= '0;
      y_min_q <= '0;
      y_max_q <= '0;
      caps_q  <= RST_CAPS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SCREEN_MAX_X: max_x_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_SCREEN_MAX_Y: max_y_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_REL_SCALE:    scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_AXIS_X_MIN:   x_min_q <= cfg_data_i[VALUE_BITS-1:0];
        CFG_AXIS_X_MAX:   x_max_q <= cfg_data_i[VALUE_BITS-1:0];
        CFG_AXIS_Y_MIN:   y_min_q <= cfg_data_i[VALUE_BITS-1:0];
        CFG_AXIS_Y_MAX:   y_max_q <= cfg_data_i[VALUE_BITS-1:0];
        CFG_DEVICE_CAPS:  caps_q  <= cfg_data_i[CAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= RST_POS_X;
      pos_y_q     <= RST_POS_Y;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_y_q    <= axis_y_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    sh_q        <= sh_d;
    rcnt_q      <= rcnt_d;
    diff_q      <= diff_d;
    span_q      <= span_d;
    pend_kind_q <= pend_kind_d;
    pend_chg_q  <= pend_chg_d;
    pend_dx_q   <= pend_dx_d;
    pend_dy_q   <= pend_dy_d;
    out_kind_q  <= out_kind_d;
    out_mask_q  <= out_mask_d;
    out_chg_q   <= out_chg_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_dx_q    <= out_dx_d;
    out_dy_q    <= out_dy_d;
  end

  assign axis_max  = axis_y_q ? max_y_q : max_x_q;
  assign axis_old  = axis_y_q ? pos_y_q : pos_x_q;
  assign value_ext = {event_value_i[VALUE_BITS-1], event_value_i};
  assign btn_bit   = BTN_W'(1) << button_id_i;
  assign fin_delta = DELTA_W'({1'b0, fin_coord}) - DELTA_W'({1'b0, axis_old});

  always_comb begin
    state_d     = state_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    held_d      = held_q;
    axis_y_d    = axis_y_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    sh_d        = sh_q;
    rcnt_d      = rcnt_q;
    diff_d      = diff_q;
    span_d      = span_q;
    pend_kind_d = pend_kind_q;
    pend_chg_d  = pend_chg_q;
    pend_dx_d   = pend_dx_q;
    pend_dy_d   = pend_dy_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_mask_d  = out_mask_q;
    out_chg_d   = out_chg_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_dx_d    = out_dx_q;
    out_dy_d    = out_dy_q;
    fin_en      = 1'b0;
    fin_coord   = axis_old;

    map_req.start    = 1'b0;
    map_req.neg      = diff_q[MAG_W-1] ^ span_q[MAG_W-1];
    map_req.diff_mag = diff_q[MAG_W-1] ? (MAG_W'(0) - diff_q) : diff_q;
    map_req.span_mag = span_q[MAG_W-1] ? (MAG_W'(0) - span_q) : span_q;
    map_req.max      = axis_max;

    // The receiver took the word on the output register.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        // Events arriving while no pointer is present are dropped outright.
        if (in_valid_i && caps_q[CAP_POINTER]) begin
          unique case (mode_i) inside
            MODE_REL_X, MODE_REL_Y: begin
              axis_y_d = (mode_i == MODE_REL_Y);
              acc_d    = REL_W'({1'b0, (mode_i == MODE_REL_Y) ? pos_y_q : pos_x_q});
              mcand_d  = {{(REL_W - VALUE_BITS){event_value_i[VALUE_BITS-1]}},
                          event_value_i};
              sh_d     = scale_q;
              rcnt_d   = REL_CNT_W'(SCALE_W - 1);
              state_d  = S_REL;
            end
            MODE_ABS_X: begin
              if (caps_q[CAP_ABS_X]) begin
                axis_y_d = 1'b0;
                diff_d   = value_ext - {x_min_q[VALUE_BITS-1], x_min_q};
                span_d   = {x_max_q[VALUE_BITS-1], x_max_q} -
                           {x_min_q[VALUE_BITS-1], x_min_q};
                state_d  = S_PREP;
              end
            end
            MODE_ABS_Y: begin
              if (caps_q[CAP_ABS_Y]) begin
                axis_y_d = 1'b1;
                diff_d   = value_ext - {y_min_q[VALUE_BITS-1], y_min_q};
                span_d   = {y_max_q[VALUE_BITS-1], y_max_q} -
                           {y_min_q[VALUE_BITS-1], y_min_q};
                state_d  = S_PREP;
              end
            end
            MODE_BUTTON: begin
              // A repeated press or release still produces a word.
              if (button_id_i != BTN_OTHER) begin
                held_d      = (event_value_i != '0) ? (held_q | btn_bit)
                                                    : (held_q & ~btn_bit);
                pend_kind_d = KIND_BUTTON;
                pend_chg_d  = btn_bit;
                pend_dx_d   = '0;
                pend_dy_d   = '0;
                state_d     = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_REL: begin
        if (sh_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = mcand_q << 1;
        sh_d    = sh_q >> 1;
        if (rcnt_q == '0) begin
          state_d = S_REL_FIN;
        end else begin
          rcnt_d = rcnt_q - 1'b1;
        end
      end
      S_REL_FIN: begin
        fin_en = 1'b1;
        if (acc_q[REL_W-1]) begin
          fin_coord = '0;
        end else if (acc_q > REL_W'(axis_max)) begin
          fin_coord = axis_max;
        end else begin
          fin_coord = acc_q[COORD_BITS-1:0];
        end
      end
      S_PREP: begin
        // A degenerate calibration range ignores the event.
        if (span_q == '0) begin
          state_d = S_IDLE;
        end else begin
          map_req.start = 1'b1;
          state_d       = S_ABS;
        end
      end
      S_ABS: begin
        if (map_rsp.done) begin
          fin_en    = 1'b1;
          fin_coord = map_rsp.coord;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_kind_d  = pend_kind_q;
          out_mask_d  = held_q;
          out_chg_d   = pend_chg_q;
          out_x_d     = pos_x_q;
          out_y_d     = pos_y_q;
          out_dx_d    = pend_dx_q;
          out_dy_d    = pend_dy_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A move finishes here: update the moved axis and record its delta.
    if (fin_en) begin
      pend_kind_d = KIND_MOVE;
      pend_chg_d  = '0;
      if (axis_y_q) begin
        pos_y_d   = fin_coord;
        pend_dx_d = '0;
        pend_dy_d = fin_delta;
      end else begin
        pos_x_d   = fin_coord;
        pend_dx_d = fin_delta;
        pend_dy_d = '0;
      end
      state_d = S_EMIT;
    end
  end

  pct_abs_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign button_mask_o    = out_mask_q;
  assign changed_button_o = out_chg_q;
  assign cursor_x_o       = out_x_q;
  assign cursor_y_o       = out_y_q;
  assign delta_x_o        = out_dx_q;
  assign delta_y_o        = out_dy_q;

  // A move word names no button and moves at most one axis.
  a_move_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_MOVE) |->
      (changed_button_o == '0 && (delta_x_o == '0 || delta_y_o == '0)))
    else $error("move word carries a button or two deltas");

  // A button word names exactly one button and no motion.
  a_button_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_BUTTON) |->
      ($onehot(changed_button_o) && delta_x_o == '0 && delta_y_o == '0))
    else $error("button word malformed");

  // The mapper only answers while an absolute event waits for it.
  a_map_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_rsp.done |-> (state_q == S_ABS))
    else $error("mapper finished outside an absolute event");

  // A pending result moves to a free output register at once.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_o) |=> out_valid_o)
    else $error("pending result not presented");

endmodule

[dv/tb_pointer_cursor_tracker_unit.sv]
module tb_pointer_cursor_tracker_unit;
  import pct_pkg::*;

  // The most negative and most positive axis readings.
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = ~VALUE_MIN;
  localparam logic [CAPS_W-1:0] CAPS_ALL =
    CAPS_W'((1 << CAP_POINTER) | (1 << CAP_ABS_X) | (1 << CAP_ABS_Y));
  localparam logic [CAPS_W-1:0] CAPS_NO_POINTER = CAPS_W'((1 << CAP_ABS_X) | (1 << CAP_ABS_Y));

  // The longest time the block may still work on an event that gives no word,
  // and the pause that follows draining before a register write or the end.
  localparam int DRAIN_CYCLES = 80;

  // One pointer event as it is put on the input channel.
  typedef struct {
    logic [MODE_W-1:0]            mode;
    logic [BTN_ID_W-1:0]          button;
    logic signed [VALUE_BITS-1:0] value;
  } pointer_event_t;

  // One result word as the block should return it.
  typedef struct {
    logic                         kind;
    logic [BTN_W-1:0]             mask;
    logic [BTN_W-1:0]             changed;
    logic [COORD_BITS-1:0]        x;
    logic [COORD_BITS-1:0]        y;
    logic signed [DELTA_W-1:0]    dx;
    logic signed [DELTA_W-1:0]    dy;
  } cursor_report_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall_o;
  logic [MODE_W-1:0]            ev_mode = MODE_REL_X;
  logic [BTN_ID_W-1:0]          ev_button = '0;
  logic signed [VALUE_BITS-1:0] ev_value = '0;

  logic                         out_valid_o;
  logic                         out_stall = 1'b0;
  logic                         result_kind_o;
  logic [BTN_W-1:0]             button_mask_o;
  logic [BTN_W-1:0]             changed_button_o;
  logic [COORD_BITS-1:0]        cursor_x_o;
  logic [COORD_BITS-1:0]        cursor_y_o;
  logic signed [DELTA_W-1:0]    delta_x_o;
  logic signed [DELTA_W-1:0]    delta_y_o;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready_o;
  cfg_reg_e                     cfg_index = CFG_SCREEN_MAX_X;
  logic [CFG_W-1:0]             cfg_data = '0;

  // Events waiting for the driver and result words still owed by the block.
  pointer_event_t pending_events[$];
  cursor_report_t expected_reports[$];

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;

  // Our own copy of the register file, kept in step with every write.
  logic [COORD_BITS-1:0]        max_x = RST_MAX_X;
  logic [COORD_BITS-1:0]        max_y = RST_MAX_Y;
  logic [SCALE_W-1:0]           scale = RST_SCALE;
  logic signed [VALUE_BITS-1:0] x_lo = '0;
  logic signed [VALUE_BITS-1:0] x_hi = '0;
  logic signed [VALUE_BITS-1:0] y_lo = '0;
  logic signed [VALUE_BITS-1:0] y_hi = '0;
  logic [CAPS_W-1:0]            caps = RST_CAPS;

  // Cursor and buttons as they should stand after every accepted event.
  logic [COORD_BITS-1:0]        cur_x = RST_POS_X;
  logic [COORD_BITS-1:0]        cur_y = RST_POS_Y;
  logic [BTN_W-1:0]             held = '0;

  pointer_cursor_tracker_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .mode_i           (ev_mode),
    .button_id_i      (ev_button),
    .event_value_i    (ev_value),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind_o),
    .button_mask_o    (button_mask_o),
    .changed_button_o (changed_button_o),
    .cursor_x_o       (cursor_x_o),
    .cursor_y_o       (cursor_y_o),
    .delta_x_o        (delta_x_o),
    .delta_y_o        (delta_y_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A hung handshake or a word that never comes ends the run here.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // A coordinate clamped to the range from zero to the screen maximum.
  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v,
                                                        input logic [COORD_BITS-1:0] maximum);
    if (v < 0) return '0;
    if (v > longint'(maximum)) return maximum;
    return COORD_BITS'(v);
  endfunction

  // Linear map of an axis reading onto the screen. The division truncates
  // toward zero; an inverted range maps the axis in reverse, and the clamp
  // saturates out-of-range quotients. A degenerate range gives -1: no move.
  function automatic longint map_reading(input longint reading,
                                         input logic signed [VALUE_BITS-1:0] lo,
                                         input logic signed [VALUE_BITS-1:0] hi,
                                         input logic [COORD_BITS-1:0] maximum);
    longint span;
    span = longint'(hi) - longint'(lo);
    if (span == 0) return -1;
    return longint'(clamp_coord((reading - longint'(lo)) * longint'(maximum) / span, maximum));
  endfunction

  // Advances the cursor state by one accepted event and queues the word that
  // the event should produce, if any.
  function automatic void track_event(input pointer_event_t ev);
    cursor_report_t        rep;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic [BTN_W-1:0]      bit_sel;
    longint                count;
    longint                mapped;
    bit                    moved;
    nx = cur_x;
    ny = cur_y;
    count = longint'(ev.value);
    moved = 1'b1;
    rep = '{default: '0};
    // Without a pointer the block drops every event.
    if (!caps[CAP_POINTER]) return;
    if (ev.mode == MODE_BUTTON) begin
      if (ev.button == BTN_OTHER) return;
      bit_sel = BTN_W'(1) << ev.button;
      // Any nonzero value is a press; a repeated press or release still reports.
      if (ev.value != 0) held = held | bit_sel;
      else held = held & ~bit_sel;
      rep.kind = KIND_BUTTON;
      rep.mask = held;
      rep.changed = bit_sel;
      rep.x = cur_x;
      rep.y = cur_y;
      expected_reports.push_back(rep);
      return;
    end
    case (ev.mode)
      MODE_REL_X: nx = clamp_coord(longint'(cur_x) + count * longint'(scale), max_x);
      MODE_REL_Y: ny = clamp_coord(longint'(cur_y) + count * longint'(scale), max_y);
      MODE_ABS_X: begin
        mapped = caps[CAP_ABS_X] ? map_reading(count, x_lo, x_hi, max_x) : -1;
        moved = (mapped >= 0);
        nx = COORD_BITS'(mapped);
      end
      MODE_ABS_Y: begin
        mapped = caps[CAP_ABS_Y] ? map_reading(count, y_lo, y_hi, max_y) : -1;
        moved = (mapped >= 0);
        ny = COORD_BITS'(mapped);
      end
      default: moved = 1'b0;
    endcase
    if (!moved) return;
    rep.kind = KIND_MOVE;
    rep.mask = held;
    rep.x = nx;
    rep.y = ny;
    rep.dx = DELTA_W'(longint'(nx) - longint'(cur_x));
    rep.dy = DELTA_W'(longint'(ny) - longint'(cur_y));
    cur_x = nx;
    cur_y = ny;
    expected_reports.push_back(rep);
  endfunction

  // Input driver. An offered word stays on the port until the block takes it;
  // only then may the sender pause or move on to the next pending event.
  always @(posedge clk_i) begin : event_driver
    pointer_event_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        track_event(pointer_event_t'{ev_mode, ev_button, ev_value});
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_events.pop_front();
          ev_mode   <= nxt.mode;
          ev_button <= nxt.button;
          ev_value  <= nxt.value;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Every word taken from the block is held against the oldest
  // outstanding expectation, field by field.
  always @(posedge clk_i) begin : report_monitor
    cursor_report_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_reports.pop_front();
          if (result_kind_o !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d", result_kind_o, want.kind));
          if (button_mask_o !== want.mask)
            report_mismatch($sformatf("button_mask %0h, want %0h", button_mask_o, want.mask));
          if (changed_button_o !== want.changed)
            report_mismatch($sformatf("changed_button %0h, want %0h",
                                      changed_button_o, want.changed));
          if (cursor_x_o !== want.x)
            report_mismatch($sformatf("cursor_x %0d, want %0d", cursor_x_o, want.x));
          if (cursor_y_o !== want.y)
            report_mismatch($sformatf("cursor_y %0d, want %0d", cursor_y_o, want.y));
          if (delta_x_o !== want.dx)
            report_mismatch($sformatf("delta_x %0d, want %0d", delta_x_o, want.dx));
          if (delta_y_o !== want.dy)
            report_mismatch($sformatf("delta_y %0d, want %0d", delta_y_o, want.dy));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_event(input logic [MODE_W-1:0] mode, input logic [BTN_ID_W-1:0] button,
                            input logic signed [VALUE_BITS-1:0] value);
    pending_events.push_back(pointer_event_t'{mode, button, value});
  endtask

  // Writes one register over the configuration channel and mirrors it in the
  // local register copy. The block masks narrow registers to their width.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCREEN_MAX_X: max_x = data[COORD_BITS-1:0];
      CFG_SCREEN_MAX_Y: max_y = data[COORD_BITS-1:0];
      CFG_REL_SCALE:    scale = data[SCALE_W-1:0];
      CFG_AXIS_X_MIN:   x_lo  = data[VALUE_BITS-1:0];
      CFG_AXIS_X_MAX:   x_hi  = data[VALUE_BITS-1:0];
      CFG_AXIS_Y_MIN:   y_lo  = data[VALUE_BITS-1:0];
      CFG_AXIS_Y_MAX:   y_hi  = data[VALUE_BITS-1:0];
      CFG_DEVICE_CAPS:  caps  = data[CAPS_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every event has been taken and every word has come back, then
  // lets the block finish any event that gives no word. Checked on the falling
  // edge so that the driver's and monitor's updates are all settled.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Draws a calibration range: full span, degenerate, inverted, arbitrary, or
  // (mostly) a narrow range around a random point.
  task automatic random_axis(output logic signed [VALUE_BITS-1:0] lo,
                             output logic signed [VALUE_BITS-1:0] hi);
    case ($urandom_range(7))
      0: begin lo = VALUE_MIN; hi = VALUE_MAX; end
      1: begin lo = $urandom; hi = lo; end
      2: begin lo = $urandom_range(60000); hi = lo - int'($urandom_range(1, 60000)); end
      3: begin lo = $urandom; hi = $urandom; end
      default: begin
        lo = int'($urandom_range(2000000)) - 1000000;
        hi = lo + int'($urandom_range(1, 5000));
      end
    endcase
  endtask

  initial begin : stimulus
    int                           send_idle_by_phase[4] = '{0, 77, 0, 21};
    int                           stall_by_phase[4] = '{0, 0, 77, 21};
    logic [CFG_W-1:0]             data;
    logic signed [VALUE_BITS-1:0] lo;
    logic signed [VALUE_BITS-1:0] hi;
    pointer_event_t               ev;
    int                           pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: the cursor starts centered, absolute
    // axes are not usable yet, so absolute events must be dropped.
    push_event(MODE_REL_X, '0, 1);
    push_event(MODE_REL_Y, '0, -1);
    push_event(MODE_ABS_X, '0, 100);
    push_event(MODE_BUTTON, 2'd0, 1);
    push_event(MODE_BUTTON, 2'd1, -1);
    push_event(MODE_BUTTON, 2'd2, VALUE_MIN);
    push_event(MODE_BUTTON, 2'd0, 1);
    push_event(MODE_BUTTON, 2'd1, 0);
    push_event(MODE_BUTTON, 2'd1, 0);
    push_event(MODE_BUTTON, BTN_OTHER, 1);
    push_event(MODE_BUTTON + 3'd1, '0, 5);
    push_event('1, '1, -1);
    push_event(MODE_REL_X, '0, VALUE_MAX);
    push_event(MODE_REL_Y, '0, VALUE_MIN);
    settle();

    // Widest X screen with the full reading range; a zero-height screen and a
    // degenerate Y calibration.
    write_reg(CFG_SCREEN_MAX_X, '1);
    write_reg(CFG_SCREEN_MAX_Y, '0);
    write_reg(CFG_REL_SCALE, 32);
    write_reg(CFG_AXIS_X_MIN, VALUE_MIN);
    write_reg(CFG_AXIS_X_MAX, VALUE_MAX);
    write_reg(CFG_AXIS_Y_MIN, 100);
    write_reg(CFG_AXIS_Y_MAX, 100);
    write_reg(CFG_DEVICE_CAPS, CAPS_ALL);
    push_event(MODE_ABS_X, '0, VALUE_MIN);
    push_event(MODE_ABS_X, '0, VALUE_MAX);
    push_event(MODE_ABS_X, '0, 0);
    push_event(MODE_ABS_Y, '0, 5);
    push_event(MODE_REL_Y, '0, 3);
    settle();

    // The X maximum drops below the current X, the Y range is inverted, and a
    // zero scale makes relative moves stand still.
    write_reg(CFG_SCREEN_MAX_X, '0);
    write_reg(CFG_SCREEN_MAX_Y, '1);
    write_reg(CFG_REL_SCALE, 0);
    write_reg(CFG_AXIS_Y_MIN, 1000);
    write_reg(CFG_AXIS_Y_MAX, -1000);
    push_event(MODE_REL_Y, '0, 7);
    push_event(MODE_ABS_Y, '0, 0);
    push_event(MODE_ABS_Y, '0, VALUE_MAX);
    push_event(MODE_ABS_Y, '0, VALUE_MIN);
    push_event(MODE_REL_X, '0, -1);
    settle();

    // A scale above the documented range, then the pointer removed entirely.
    write_reg(CFG_REL_SCALE, '1);
    write_reg(CFG_DEVICE_CAPS, CAPS_NO_POINTER);
    push_event(MODE_REL_X, '0, 1);
    push_event(MODE_BUTTON, 2'd0, 1);
    settle();

    // Random part: each handshake pressure setting runs over several register
    // settings, every register rewritten between blocks of events.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      for (int blk = 0; blk < 3; blk++) begin
        // Bits above a register's width carry junk that the block must ignore.
        for (int axis = 0; axis < 2; axis++) begin
          data = $urandom;
          case ($urandom_range(7))
            0: data[COORD_BITS-1:0] = '0;
            1: data[COORD_BITS-1:0] = '1;
            default: data[COORD_BITS-1:0] = $urandom_range(4095);
          endcase
          write_reg(axis == 0 ? CFG_SCREEN_MAX_X : CFG_SCREEN_MAX_Y, data);
        end
        data = $urandom;
        case ($urandom_range(9))
          0: data[SCALE_W-1:0] = '0;
          1: data[SCALE_W-1:0] = '1;
          2: data[SCALE_W-1:0] = 32;
          3: data[SCALE_W-1:0] = 1;
          default: data[SCALE_W-1:0] = $urandom_range(1, 32);
        endcase
        write_reg(CFG_REL_SCALE, data);
        random_axis(lo, hi);
        write_reg(CFG_AXIS_X_MIN, lo);
        write_reg(CFG_AXIS_X_MAX, hi);
        random_axis(lo, hi);
        write_reg(CFG_AXIS_Y_MIN, lo);
        write_reg(CFG_AXIS_Y_MAX, hi);
        data = $urandom;
        data[CAPS_W-1:0] = ($urandom_range(3) != 0) ? CAPS_ALL :
                           CAPS_W'(($urandom_range(3) << 1) | (1 << CAP_POINTER));
        write_reg(CFG_DEVICE_CAPS, data);

        for (int n = 0; n < 44; n++) begin
          pick = $urandom_range(99);
          ev.button = $urandom_range(3);
          if (pick < 40) begin
            ev.mode = (pick < 20) ? MODE_REL_X : MODE_REL_Y;
            case ($urandom_range(9))
              0: ev.value = $urandom;
              1: ev.value = int'($urandom_range(4000)) - 2000;
              default: ev.value = int'($urandom_range(64)) - 32;
            endcase
          end else if (pick < 76) begin
            // Most readings fall in or just around the calibrated range.
            ev.mode = (pick < 58) ? MODE_ABS_X : MODE_ABS_Y;
            lo = (ev.mode == MODE_ABS_X) ? x_lo : y_lo;
            hi = (ev.mode == MODE_ABS_X) ? x_hi : y_hi;
            if ($urandom_range(9) < 7) begin
              ev.value = VALUE_BITS'(longint'(lo) + (longint'(hi) - longint'(lo)) *
                                     longint'($urandom_range(1000)) / 1000 +
                                     longint'($urandom_range(40)) - 20);
            end else begin
              ev.value = $urandom;
            end
          end else if (pick < 95) begin
            ev.mode = MODE_BUTTON;
            ev.button = ($urandom_range(9) == 0) ? BTN_OTHER : BTN_ID_W'($urandom_range(2));
            ev.value = $urandom_range(1) ? VALUE_BITS'($urandom) : '0;
          end else begin
            ev.mode = MODE_W'($urandom_range(int'(MODE_BUTTON) + 1, (1 << MODE_W) - 1));
            ev.value = $urandom;
          end
          pending_events.push_back(ev);
        end
        settle();
      end
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
